// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the key codec RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in key codec");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in key codec");

`endif

// ----- hdl/sikc_pkg.sv -----
// Types and constants of the symmetric index key codec.
// Used by the channel interfaces and every module of the codec.
package sikc_pkg;

  localparam int KEY_W      = 38;
  localparam int IDX_W      = 8;
  localparam int K_W        = 6;
  localparam int RADIX_W    = 9;
  localparam int N_IDX      = 4;
  localparam int DIV_STEPS  = 4;
  localparam int N_DIV_STG  = (N_IDX * KEY_W) / DIV_STEPS;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SYM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_STATES = 2'd2;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // One item in flight. acc is the key being built on encode and the
  // running dividend on decode; dig holds canonical indices or digits.
  typedef struct packed {
    logic                      func;
    logic [KEY_W-1:0]          acc;
    logic [RADIX_W-1:0]        rem;
    logic [N_IDX-1:0][IDX_W-1:0] dig;
  } stage_t;

endpackage

// ----- hdl/sikc_if.sv -----
// Valid/ready channel interfaces for the input and result items.
// Depends on sikc_pkg for the field widths.
interface sikc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [sikc_pkg::K_W-1:0]       k_in;
  logic [sikc_pkg::IDX_W-1:0]     idx_a;
  logic [sikc_pkg::IDX_W-1:0]     idx_b;
  logic [sikc_pkg::IDX_W-1:0]     idx_c;
  logic [sikc_pkg::IDX_W-1:0]     idx_d;
  logic [sikc_pkg::KEY_W-1:0]     key_in;
  modport source (output valid, func, k_in, idx_a, idx_b, idx_c, idx_d, key_in,
                  input ready);
  modport sink (input valid, func, k_in, idx_a, idx_b, idx_c, idx_d, key_in,
                output ready);
endinterface

interface sikc_out_if;
  logic                           valid;
  logic                           ready;
  logic [sikc_pkg::KEY_W-1:0]     key_out;
  logic [sikc_pkg::K_W-1:0]       k_out;
  logic [sikc_pkg::IDX_W-1:0]     out_a;
  logic [sikc_pkg::IDX_W-1:0]     out_b;
  logic [sikc_pkg::IDX_W-1:0]     out_c;
  logic [sikc_pkg::IDX_W-1:0]     out_d;
  logic                           overflow;
  modport source (output valid, key_out, k_out, out_a, out_b, out_c, out_d, overflow,
                  input ready);
  modport sink (input valid, key_out, k_out, out_a, out_b, out_c, out_d, overflow,
                output ready);
endinterface

// ----- hdl/symmetric_index_key_codec.sv -----
// Symmetric index key codec. One item is accepted per clock cycle unless a
// stalled output has backed up the pipeline. Items pass canonical ordering
// and then 38 pipeline stages. On encode the first four of those stages
// each do one Horner multiply-add of the mixed-radix key; on decode the 38
// stages run four successive restoring divisions by the decode radix, four
// quotient bits per stage. Each stage holds its item while the stage after
// it is full and stalled, so bubbles are absorbed and no item is lost or
// repeated. Configuration must be written while idle.
`include "assert_macros.svh"

module symmetric_index_key_codec #(
  parameter int MAX_STATES = 256,
  parameter int MAX_ORDER  = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sikc_in_if.sink                             in_ch,
  sikc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sikc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sikc_pkg::RADIX_W-1:0]        cfg_data
);

  localparam int NSTG = sikc_pkg::N_DIV_STG + 1;
  localparam int KW   = sikc_pkg::KEY_W;

  logic [sikc_pkg::RADIX_W-1:0] num_states_r, decode_states_r, radix_dec;
  logic                         reverse_sym_r;
  logic [NSTG:0]                en;
  logic [NSTG-1:0]              v;
  sikc_pkg::stage_t             rec [NSTG];
  sikc_pkg::stage_t             last;
  logic                         dec_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r    <= sikc_pkg::RADIX_W'(MAX_STATES);
      reverse_sym_r   <= 1'b0;
      decode_states_r <= sikc_pkg::RADIX_W'(MAX_STATES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sikc_pkg::REG_NUM_STATES:    num_states_r    <= cfg_data;
        sikc_pkg::REG_REVERSE_SYM:   reverse_sym_r   <= cfg_data[0];
        sikc_pkg::REG_DECODE_STATES: decode_states_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero decode radix behaves as radix one.
  assign radix_dec = (decode_states_r == '0) ? sikc_pkg::RADIX_W'(1) : decode_states_r;

  assign en[NSTG] = out_ch.ready;
  generate
    for (genvar i = 0; i < NSTG; i++) begin : g_en
      assign en[i] = !v[i] || en[i+1];
    end
  endgenerate

  assign in_ch.ready = en[0];

  sikc_canon u_canon (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en[0]),
    .in_valid    (in_ch.valid),
    .func        (in_ch.func),
    .k_in        (in_ch.k_in),
    .idx_a       (in_ch.idx_a),
    .idx_b       (in_ch.idx_b),
    .idx_c       (in_ch.idx_c),
    .idx_d       (in_ch.idx_d),
    .key_in      (in_ch.key_in),
    .reverse_sym (reverse_sym_r),
    .valid_r     (v[0]),
    .rec_r       (rec[0])
  );

  generate
    for (genvar i = 1; i < NSTG; i++) begin : g_stage
      sikc_pipe_stage #(.STAGE(i - 1)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[i]),
        .in_valid  (v[i-1]),
        .in_rec    (rec[i-1]),
        .radix_enc (num_states_r),
        .radix_dec (radix_dec),
        .valid_r   (v[i]),
        .rec_r     (rec[i])
      );
    end
  endgenerate

  assign last    = rec[NSTG-1];
  assign dec_ovf = last.acc > KW'(MAX_ORDER);

  always_comb begin
    out_ch.valid = v[NSTG-1];
    if (last.func == sikc_pkg::FUNC_DECODE) begin
      out_ch.key_out  = '0;
      out_ch.overflow = dec_ovf;
      out_ch.k_out    = dec_ovf ? sikc_pkg::K_W'(MAX_ORDER) : last.acc[sikc_pkg::K_W-1:0];
      out_ch.out_a    = last.dig[0];
      out_ch.out_b    = last.dig[1];
      out_ch.out_c    = last.dig[2];
      out_ch.out_d    = last.dig[3];
    end else begin
      out_ch.key_out  = last.acc;
      out_ch.overflow = 1'b0;
      out_ch.k_out    = '0;
      out_ch.out_a    = '0;
      out_ch.out_b    = '0;
      out_ch.out_c    = '0;
      out_ch.out_d    = '0;
    end
  end

  `ASSERT_SAME(a_ovf_sat, out_ch.valid && out_ch.overflow, out_ch.k_out == sikc_pkg::K_W'(MAX_ORDER))
  `ASSERT_SAME(a_ovf_nokey, out_ch.valid && out_ch.overflow, out_ch.key_out == '0)
  `ASSERT_NEXT(a_accept_lands, in_ch.valid && in_ch.ready, v[0])
  `ASSERT_NEXT(a_out_held, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.key_out))

endmodule

// ----- hdl/sikc_canon.sv -----
// First pipeline stage: canonical reordering of the four indices.
// Depends on sikc_pkg.
module sikc_canon (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        func,
  input  logic [sikc_pkg::K_W-1:0]    k_in,
  input  sikc_pkg::idx_t              idx_a,
  input  sikc_pkg::idx_t              idx_b,
  input  sikc_pkg::idx_t              idx_c,
  input  sikc_pkg::idx_t              idx_d,
  input  logic [sikc_pkg::KEY_W-1:0]  key_in,
  input  logic                        reverse_sym,
  output logic                        valid_r,
  output sikc_pkg::stage_t            rec_r
);

  sikc_pkg::stage_t rec_nxt;
  sikc_pkg::idx_t   a, b, c, d, t, mac, mbd;

  always_comb begin
    a = idx_a;
    b = idx_b;
    c = idx_c;
    d = idx_d;
    t = '0;
    mac = '0;
    mbd = '0;
    if (reverse_sym) begin
      if (c < a) begin t = a; a = c; c = t; end
      if (d < b) begin t = b; b = d; d = t; end
      if (b < a) begin
        t = a; a = b; b = t;
        t = c; c = d; d = t;
      end
      if (a == b && d < c) begin t = c; c = d; d = t; end
    end else begin
      mac = (a < c) ? a : c;
      mbd = (b < d) ? b : d;
      if (mac > mbd) begin
        t = a; a = b; b = t;
        t = c; c = d; d = t;
      end
      if (a > c) begin
        t = a; a = c; c = t;
        t = b; b = d; d = t;
      end
      if (a == b && d < c) begin t = c; c = d; d = t; end
      if (a == c && d < b) begin t = b; b = d; d = t; end
      if (a == d && c < b) begin t = b; b = c; c = t; end
    end

    rec_nxt.func = func;
    rec_nxt.rem  = '0;
    if (func == sikc_pkg::FUNC_DECODE) begin
      rec_nxt.acc = key_in;
      rec_nxt.dig = '0;
    end else begin
      rec_nxt.acc = {{(sikc_pkg::KEY_W-sikc_pkg::K_W){1'b0}}, k_in};
      rec_nxt.dig = {d, c, b, a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// ----- hdl/sikc_pipe_stage.sv -----
// One stage of the codec pipeline: a Horner multiply-add on encode in the
// first stages, and four restoring division steps on decode. Uses sikc_pkg.
module sikc_pipe_stage #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  sikc_pkg::stage_t              in_rec,
  input  logic [sikc_pkg::RADIX_W-1:0]  radix_enc,
  input  logic [sikc_pkg::RADIX_W-1:0]  radix_dec,
  output logic                          valid_r,
  output sikc_pkg::stage_t              rec_r
);

  localparam int KW   = sikc_pkg::KEY_W;
  localparam int RW   = sikc_pkg::RADIX_W;
  localparam int NS   = sikc_pkg::DIV_STEPS;
  localparam int BASE = STAGE * NS;

  logic [KW-1:0]                               horner;
  logic [NS:0][KW-1:0]                         acc_w;
  logic [NS:0][RW-1:0]                         rem_w;
  logic [NS:0][sikc_pkg::N_IDX-1:0][sikc_pkg::IDX_W-1:0] dig_w;
  sikc_pkg::stage_t                            rec_nxt;

  generate
    if (STAGE < sikc_pkg::N_IDX) begin : g_horner
      logic [KW+RW-1:0] prod;
      assign prod   = in_rec.acc * radix_enc;
      assign horner = KW'(prod + (KW+RW)'(in_rec.dig[STAGE]));
    end else begin : g_pass
      assign horner = in_rec.acc;
    end
  endgenerate

  assign acc_w[0] = in_rec.acc;
  assign rem_w[0] = in_rec.rem;
  assign dig_w[0] = in_rec.dig;

  // A boundary every KEY_W steps closes one division: the remainder is a
  // digit (lowest first) and the quotient becomes the next dividend.
  generate
    for (genvar j = 0; j < NS; j++) begin : g_step
      localparam int  S    = BASE + j;
      localparam bit  LAST = ((S + 1) % KW) == 0;
      localparam int  DPOS = sikc_pkg::N_IDX - 1 - (S / KW);
      logic [RW:0]   sh;
      logic          ge;
      logic [RW-1:0] rem_s;
      assign sh    = {rem_w[j], acc_w[j][KW-1]};
      assign ge    = sh >= {1'b0, radix_dec};
      assign rem_s = ge ? RW'(sh - {1'b0, radix_dec}) : sh[RW-1:0];
      assign acc_w[j+1] = {acc_w[j][KW-2:0], ge};
      if (LAST) begin : g_close
        for (genvar p = 0; p < sikc_pkg::N_IDX; p++) begin : g_pos
          if (p == DPOS) begin : g_put
            assign dig_w[j+1][p] = rem_s[sikc_pkg::IDX_W-1:0];
          end else begin : g_keep
            assign dig_w[j+1][p] = dig_w[j][p];
          end
        end
        assign rem_w[j+1] = '0;
      end else begin : g_mid
        assign dig_w[j+1] = dig_w[j];
        assign rem_w[j+1] = rem_s;
      end
    end
  endgenerate

  always_comb begin
    rec_nxt = in_rec;
    if (in_rec.func == sikc_pkg::FUNC_DECODE) begin
      rec_nxt.acc = acc_w[NS];
      rec_nxt.rem = rem_w[NS];
      rec_nxt.dig = dig_w[NS];
    end else begin
      rec_nxt.acc = horner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      rec_r <= rec_nxt;
    end
  end

endmodule
